// ===== sv/ist_pkg.sv =====
// shared types, constants and command codes for the indexed sequence table
`default_nettype none
package ist_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int POS_W       = 7;
    localparam int ADDR_W      = $clog2(CAPACITY);

    // request types
    localparam logic [2:0] OP_INSERT_AT     = 3'd0;
    localparam logic [2:0] OP_INSERT_SORTED = 3'd1;
    localparam logic [2:0] OP_ERASE_AT      = 3'd2;
    localparam logic [2:0] OP_REMOVE_ALL    = 3'd3;
    localparam logic [2:0] OP_READ_AT       = 3'd4;
    localparam logic [2:0] OP_WRITE_AT      = 3'd5;
    localparam logic [2:0] OP_FIND          = 3'd6;

    // index register updates
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_INC   = 3'd1;
    localparam logic [2:0] IDX_DEC   = 3'd2;
    localparam logic [2:0] IDX_COUNT = 3'd3;

    // read address select
    localparam logic [1:0] RA_IDX  = 2'd0;
    localparam logic [1:0] RA_PREV = 2'd1;
    localparam logic [1:0] RA_NEXT = 2'd2;

    // write address select
    localparam logic [1:0] WA_IDX  = 2'd0;
    localparam logic [1:0] WA_TGT  = 2'd1;
    localparam logic [1:0] WA_WPTR = 2'd2;

    // count register updates
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_WPTR = 2'd3;

    typedef struct packed {
        logic [2:0]             req_type;
        logic [POS_W-1:0]       in_pos;
        logic [VALUE_WIDTH-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic                   ok;
        logic [VALUE_WIDTH-1:0] read_data;
        logic [POS_W-1:0]       out_pos;
        logic [POS_W-1:0]       removed_count;
        logic [POS_W-1:0]       item_count;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       wr_from_mem;
        logic [2:0] idx_op;
        logic       set_opos;
        logic [1:0] cnt_op;
        logic       rem_inc;
        logic       w_inc;
        logic       set_ok;
        logic       set_rdata;
        logic       push;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       pre_ok;
        logic       scan_more;
        logic       up_more;
        logic       dn_more;
        logic       less;
        logic       equal;
        logic       busy;
    } stat_t;

endpackage
`default_nettype wire

// ===== sv/ist_dp.sv =====
// datapath: entry memory, count, index pointers and result register
`default_nettype none
module ist_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ist_pkg::req_t req,
    input  wire ist_pkg::cmd_t cmd,
    output ist_pkg::stat_t     st,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ist_pkg::rsp_t      rsp
);

    logic [ist_pkg::VALUE_WIDTH-1:0] mem [ist_pkg::CAPACITY];
    logic [ist_pkg::VALUE_WIDTH-1:0] mem_q;

    ist_pkg::req_t                   req_reg;
    logic [ist_pkg::POS_W-1:0]       count_reg, count_next;
    logic [ist_pkg::POS_W-1:0]       idx_reg, idx_next;
    logic [ist_pkg::POS_W-1:0]       wptr_reg;
    logic [ist_pkg::POS_W-1:0]       opos_reg;
    logic [ist_pkg::POS_W-1:0]       rem_reg;
    logic                            ok_reg;
    logic [ist_pkg::VALUE_WIDTH-1:0] rdata_reg;
    logic                            out_valid_reg;

    logic [ist_pkg::POS_W-1:0]       idx_init, tgt, rd_addr, wr_addr, idx_inc;
    logic [ist_pkg::VALUE_WIDTH-1:0] wr_data;
    logic                            pre_ok;

    assign idx_inc = idx_reg + 7'd1;
    assign tgt     = (req_reg.req_type == ist_pkg::OP_INSERT_SORTED) ? opos_reg
                                                                      : req_reg.in_pos;

    always_comb
    begin
        unique case (req.req_type)
            ist_pkg::OP_INSERT_AT: idx_init = count_reg;
            ist_pkg::OP_ERASE_AT,
            ist_pkg::OP_READ_AT,
            ist_pkg::OP_WRITE_AT:  idx_init = req.in_pos;
            default:               idx_init = '0;
        endcase
    end

    always_comb
    begin
        unique case (req_reg.req_type)
            ist_pkg::OP_INSERT_AT:
                pre_ok = (count_reg < 7'(ist_pkg::CAPACITY)) && (req_reg.in_pos <= count_reg);
            ist_pkg::OP_INSERT_SORTED:
                pre_ok = count_reg < 7'(ist_pkg::CAPACITY);
            ist_pkg::OP_ERASE_AT,
            ist_pkg::OP_READ_AT,
            ist_pkg::OP_WRITE_AT:
                pre_ok = req_reg.in_pos < count_reg;
            ist_pkg::OP_REMOVE_ALL,
            ist_pkg::OP_FIND:
                pre_ok = 1'b1;
            default:
                pre_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            ist_pkg::RA_PREV: rd_addr = idx_reg - 7'd1;
            ist_pkg::RA_NEXT: rd_addr = idx_inc;
            default:          rd_addr = idx_reg;
        endcase
        unique case (cmd.wr_sel)
            ist_pkg::WA_TGT:  wr_addr = tgt;
            ist_pkg::WA_WPTR: wr_addr = wptr_reg;
            default:          wr_addr = idx_reg;
        endcase
        wr_data = cmd.wr_from_mem ? mem_q : req_reg.item_value;
    end

    always_comb
    begin
        unique case (cmd.idx_op)
            ist_pkg::IDX_INC:   idx_next = idx_inc;
            ist_pkg::IDX_DEC:   idx_next = idx_reg - 7'd1;
            ist_pkg::IDX_COUNT: idx_next = count_reg;
            default:            idx_next = idx_reg;
        endcase
        if (cmd.load)
        begin
            idx_next = idx_init;
        end
        unique case (cmd.cnt_op)
            ist_pkg::CNT_INC:  count_next = count_reg + 7'd1;
            ist_pkg::CNT_DEC:  count_next = count_reg - 7'd1;
            ist_pkg::CNT_WPTR: count_next = wptr_reg;
            default:           count_next = count_reg;
        endcase
    end

    // entry memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            mem_q <= mem[rd_addr[ist_pkg::ADDR_W-1:0]];
        end
        if (cmd.wr_en)
        begin
            mem[wr_addr[ist_pkg::ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            wptr_reg      <= '0;
            opos_reg      <= '0;
            rem_reg       <= '0;
            ok_reg        <= 1'b0;
            rdata_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.load)
            begin
                wptr_reg  <= '0;
                opos_reg  <= '0;
                rem_reg   <= '0;
                ok_reg    <= 1'b0;
                rdata_reg <= '0;
            end
            else
            begin
                if (cmd.w_inc)
                begin
                    wptr_reg <= wptr_reg + 7'd1;
                end
                if (cmd.set_opos)
                begin
                    opos_reg <= idx_reg;
                end
                if (cmd.rem_inc)
                begin
                    rem_reg <= rem_reg + 7'd1;
                end
                if (cmd.set_ok)
                begin
                    ok_reg <= 1'b1;
                end
                if (cmd.set_rdata)
                begin
                    rdata_reg <= mem_q;
                end
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.op        = req_reg.req_type;
    assign st.pre_ok    = pre_ok;
    assign st.scan_more = idx_reg < count_reg;
    assign st.up_more   = idx_reg > tgt;
    assign st.dn_more   = idx_inc < count_reg;
    assign st.less      = mem_q < req_reg.item_value;
    assign st.equal     = mem_q == req_reg.item_value;
    assign st.busy      = out_valid_reg;

    assign rsp_valid         = out_valid_reg;
    assign rsp.ok            = ok_reg;
    assign rsp.read_data     = rdata_reg;
    assign rsp.out_pos       = opos_reg;
    assign rsp.removed_count = rem_reg;
    assign rsp.item_count    = count_reg;

endmodule
`default_nettype wire

// ===== sv/ist_ctrl.sv =====
// controller state machine sequencing each request over the datapath
`default_nettype none
module ist_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ist_pkg::stat_t st,
    output ist_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_SCAN_RD = 4'd2;
    localparam logic [3:0] S_SCAN_EX = 4'd3;
    localparam logic [3:0] S_UP_RD   = 4'd4;
    localparam logic [3:0] S_UP_WR   = 4'd5;
    localparam logic [3:0] S_DN_RD   = 4'd6;
    localparam logic [3:0] S_DN_WR   = 4'd7;
    localparam logic [3:0] S_REM_RD  = 4'd8;
    localparam logic [3:0] S_REM_EX  = 4'd9;
    localparam logic [3:0] S_READ_EX = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;

    logic [3:0] state_reg, state_next;

    assign req_stall = !((state_reg == S_IDLE) && !st.busy);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!st.pre_ok)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    unique case (st.op)
                        ist_pkg::OP_INSERT_AT:  state_next = S_UP_RD;
                        ist_pkg::OP_INSERT_SORTED,
                        ist_pkg::OP_FIND:       state_next = S_SCAN_RD;
                        ist_pkg::OP_ERASE_AT:   state_next = S_DN_RD;
                        ist_pkg::OP_REMOVE_ALL: state_next = S_REM_RD;
                        ist_pkg::OP_READ_AT:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = ist_pkg::RA_IDX;
                            state_next = S_READ_EX;
                        end
                        ist_pkg::OP_WRITE_AT:
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = ist_pkg::WA_IDX;
                            cmd.set_ok = 1'b1;
                            state_next = S_FIN;
                        end
                        default:                state_next = S_FIN;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (st.scan_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ist_pkg::RA_IDX;
                    state_next = S_SCAN_EX;
                end
                else if (st.op == ist_pkg::OP_INSERT_SORTED)
                begin
                    cmd.set_opos = 1'b1;
                    state_next   = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN_EX:
            begin
                if (st.op == ist_pkg::OP_INSERT_SORTED)
                begin
                    if (st.less)
                    begin
                        cmd.idx_op = ist_pkg::IDX_INC;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        cmd.set_opos = 1'b1;
                        cmd.idx_op   = ist_pkg::IDX_COUNT;
                        state_next   = S_UP_RD;
                    end
                end
                else if (st.equal)
                begin
                    cmd.set_opos = 1'b1;
                    cmd.set_ok   = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.idx_op = ist_pkg::IDX_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_UP_RD:
            begin
                if (st.up_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ist_pkg::RA_PREV;
                    state_next = S_UP_WR;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = ist_pkg::WA_TGT;
                    cmd.cnt_op = ist_pkg::CNT_INC;
                    cmd.set_ok = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_UP_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = ist_pkg::WA_IDX;
                cmd.wr_from_mem = 1'b1;
                cmd.idx_op      = ist_pkg::IDX_DEC;
                state_next      = S_UP_RD;
            end
            S_DN_RD:
            begin
                if (st.dn_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ist_pkg::RA_NEXT;
                    state_next = S_DN_WR;
                end
                else
                begin
                    cmd.cnt_op = ist_pkg::CNT_DEC;
                    cmd.set_ok = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DN_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = ist_pkg::WA_IDX;
                cmd.wr_from_mem = 1'b1;
                cmd.idx_op      = ist_pkg::IDX_INC;
                state_next      = S_DN_RD;
            end
            S_REM_RD:
            begin
                if (st.scan_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ist_pkg::RA_IDX;
                    state_next = S_REM_EX;
                end
                else
                begin
                    cmd.cnt_op = ist_pkg::CNT_WPTR;
                    cmd.set_ok = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_REM_EX:
            begin
                if (st.equal)
                begin
                    cmd.rem_inc = 1'b1;
                end
                else
                begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_sel      = ist_pkg::WA_WPTR;
                    cmd.wr_from_mem = 1'b1;
                    cmd.w_inc       = 1'b1;
                end
                cmd.idx_op = ist_pkg::IDX_INC;
                state_next = S_REM_RD;
            end
            S_READ_EX:
            begin
                cmd.set_rdata = 1'b1;
                cmd.set_ok    = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                cmd.push   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/indexed_sequence_table.sv =====
// top level: ordered value list with count, controller plus datapath
// read/write/failed requests: check state, a read step for reads only, then finish sets result valid
// insert_at and erase_at shift entries one at a time, one memory read and write each
// insert_sorted, find and remove_all walk the list with a read step and a compare step per entry
// throughput: one request at a time, next transfer after the result transfer
// reset: asynchronous active low clears count, state and result valid; entries stay undefined
`default_nettype none
module indexed_sequence_table (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ist_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ist_pkg::rsp_t      rsp
);

    // command and status between the sequencer and the datapath
    ist_pkg::cmd_t  cmd;
    ist_pkg::stat_t st;

    // sequencer: one state per read or write step of the list walk
    ist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: entry memory, pointers and the result register that holds
    // the result until its transfer completes
    ist_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ===== sv/ist_checker.sv =====
// port level checker for the indexed sequence table and its bind
`default_nettype none
module ist_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire ist_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.item_count <= 7'(ist_pkg::CAPACITY))
        else $error("count above capacity");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.read_data == '0 && rsp.removed_count == '0)
        else $error("failed result carries data");

endmodule

bind indexed_sequence_table ist_checker u_ist_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
`default_nettype wire

// ===== bench/tb_indexed_sequence_table.sv =====
// testbench for the indexed sequence table: directed and random list requests checked against a list model
`default_nettype none

// list model plus queue of expected results
class ist_scoreboard;
    logic [31:0] vals[$];
    ist_pkg::rsp_t pending[$];
    int errors;

    function void note_request(ist_pkg::req_t r);
        ist_pkg::rsp_t e;
        int i;
        int n;
        e = '0;
        case (r.req_type)
            ist_pkg::OP_INSERT_AT:
                if (vals.size() < ist_pkg::CAPACITY && r.in_pos <= vals.size())
                begin
                    vals.insert(r.in_pos, r.item_value);
                    e.ok = 1'b1;
                end
            ist_pkg::OP_INSERT_SORTED:
                if (vals.size() < ist_pkg::CAPACITY)
                begin
                    i = 0;
                    while (i < vals.size() && vals[i] < r.item_value)
                        i++;
                    vals.insert(i, r.item_value);
                    e.out_pos = 7'(i);
                    e.ok = 1'b1;
                end
            ist_pkg::OP_ERASE_AT:
                if (r.in_pos < vals.size())
                begin
                    vals.delete(r.in_pos);
                    e.ok = 1'b1;
                end
            ist_pkg::OP_REMOVE_ALL:
            begin
                n = 0;
                for (i = vals.size() - 1; i >= 0; i--)
                    if (vals[i] == r.item_value)
                    begin
                        vals.delete(i);
                        n++;
                    end
                e.removed_count = 7'(n);
                e.ok = 1'b1;
            end
            ist_pkg::OP_READ_AT:
                if (r.in_pos < vals.size())
                begin
                    e.read_data = vals[r.in_pos];
                    e.ok = 1'b1;
                end
            ist_pkg::OP_WRITE_AT:
                if (r.in_pos < vals.size())
                begin
                    vals[r.in_pos] = r.item_value;
                    e.ok = 1'b1;
                end
            ist_pkg::OP_FIND:
                for (i = 0; i < vals.size(); i++)
                    if (!e.ok && vals[i] == r.item_value)
                    begin
                        e.ok = 1'b1;
                        e.out_pos = 7'(i);
                    end
            default: ;
        endcase
        e.item_count = 7'(vals.size());
        pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    task check_result(ist_pkg::rsp_t g);
        ist_pkg::rsp_t e;
        if (pending.size() == 0)
        begin
            report("unexpected result", 1, 0);
            return;
        end
        e = pending.pop_front();
        if (g.ok !== e.ok) report("ok", g.ok, e.ok);
        if (g.read_data !== e.read_data) report("read_data", g.read_data, e.read_data);
        if (g.out_pos !== e.out_pos) report("out_pos", g.out_pos, e.out_pos);
        if (g.removed_count !== e.removed_count)
            report("removed_count", g.removed_count, e.removed_count);
        if (g.item_count !== e.item_count) report("item_count", g.item_count, e.item_count);
    endtask
endclass

module tb_indexed_sequence_table;
    timeunit 1ns;
    timeprecision 1ps;

    // request type outside the defined set
    localparam logic [2:0] OP_BAD = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    ist_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    ist_pkg::rsp_t rsp;

    ist_scoreboard board = new();
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    indexed_sequence_table dut (.*);

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // small pool of values so that find and remove_all hit often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0;
            2, 3: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // build a request; positions mostly inside the list, sometimes past it
    function automatic ist_pkg::req_t random_request();
        ist_pkg::req_t r;
        int n;
        n = board.vals.size();
        r.req_type = 3'($urandom_range(0, 7));
        // keep the list from draining: bias toward inserts when short
        if (n < 8 && $urandom_range(0, 2) == 0)
            r.req_type = $urandom_range(0, 1) ? ist_pkg::OP_INSERT_AT
                                              : ist_pkg::OP_INSERT_SORTED;
        case ($urandom_range(0, 9))
            0: r.in_pos = 7'($urandom_range(0, 127));
            1: r.in_pos = 7'(n);
            default: r.in_pos = (n == 0) ? 7'd0 : 7'($urandom_range(0, n - 1));
        endcase
        r.item_value = pick_value();
        return r;
    endfunction

    // offer one request and hold it until transfer; model updated at transfer
    task send(ist_pkg::req_t r);
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
    endtask

    // sender: random bursts and gaps
    task drive_burst(int n);
        int k;
        for (k = 0; k < n; k++)
            send(random_request());
    endtask

    task pause(int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // receiver: stall pattern plus one long hold-off to back up the block
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                rsp_stall <= 1'b1;
            else
                case ($urandom_range(0, 3))
                    0: rsp_stall <= 1'b1;
                    default: rsp_stall <= ($urandom_range(0, 9) < 2);
                endcase
        end
    end

    // result checking and watchdog on the same edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result(rsp);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int k;
        int b;
        ist_pkg::req_t r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list corner cases, then a short list built and queried
        r = '0; r.req_type = ist_pkg::OP_READ_AT; send(r);
        r.req_type = ist_pkg::OP_ERASE_AT; send(r);
        r.req_type = ist_pkg::OP_WRITE_AT; send(r);
        r.req_type = ist_pkg::OP_FIND; send(r);
        r.req_type = ist_pkg::OP_REMOVE_ALL; send(r);
        r.req_type = OP_BAD; send(r);
        r.req_type = ist_pkg::OP_INSERT_AT; r.in_pos = 7'd1; send(r);      // past the end
        r.in_pos = 7'd0; r.item_value = 32'hFFFF_FFFF; send(r);
        r.req_type = ist_pkg::OP_INSERT_SORTED; r.item_value = 32'h0; send(r);
        r.item_value = 32'h8000_0000; send(r);
        r.item_value = 32'hFFFF_FFFF; send(r);                      // duplicate goes first
        r.req_type = ist_pkg::OP_FIND; send(r);
        r.req_type = ist_pkg::OP_READ_AT; r.in_pos = 7'd3; send(r);
        r.in_pos = 7'd127; send(r);
        r.req_type = ist_pkg::OP_WRITE_AT; r.in_pos = 7'd0; r.item_value = 32'h5555_AAAA;
        send(r);
        r.req_type = ist_pkg::OP_REMOVE_ALL; r.item_value = 32'hFFFF_FFFF; send(r);
        r.req_type = ist_pkg::OP_ERASE_AT; r.in_pos = 7'd0; send(r);

        // fill to capacity, then try both inserts, a read and an erase on a full list
        for (k = 0; k < ist_pkg::CAPACITY; k++)
        begin
            r.req_type = ist_pkg::OP_INSERT_SORTED;
            r.item_value = $urandom;
            if (board.vals.size() < ist_pkg::CAPACITY) send(r);
        end
        r.req_type = ist_pkg::OP_INSERT_AT; r.in_pos = 7'd0; send(r);
        r.req_type = ist_pkg::OP_INSERT_SORTED; send(r);
        r.req_type = ist_pkg::OP_READ_AT; r.in_pos = 7'(ist_pkg::CAPACITY - 1); send(r);
        r.req_type = ist_pkg::OP_ERASE_AT; r.in_pos = 7'(ist_pkg::CAPACITY - 1); send(r);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            drive_burst(6);
        join

        // random part in bursts
        k = 0;
        while (k < 460)
        begin
            b = $urandom_range(1, 20);
            drive_burst(b);
            k += b;
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 12));
        end
        req_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
